FILE: design/sfc_pkg.sv
package sfc_pkg;

	// Fixed-point layout
	localparam int unsigned COORD_W   = 16;  // Q12.4 signed
	localparam int unsigned RADIUS_W  = 15;  // Q11.4 unsigned
	localparam int unsigned NORMAL_W  = 16;  // Q2.14 signed
	localparam int unsigned NORM_FRAC = 14;
	localparam int unsigned PROD_W    = COORD_W + NORMAL_W;
	// three products plus shifted offset stay below 2^32 in magnitude
	localparam int unsigned DIST_W    = 34;
	localparam int unsigned PLANE_W   = 64;
	localparam int unsigned NUM_PLANE_REGS = 6;
	localparam int unsigned CFG_IDX_W = 3;

	// Result codes
	localparam logic [1:0] VERDICT_INSIDE       = 2'd0;
	localparam logic [1:0] VERDICT_INTERSECTING = 2'd1;
	localparam logic [1:0] VERDICT_OUTSIDE      = 2'd2;

	// Packed plane word: nx 15:0, ny 31:16, nz 47:32, d 63:48
	typedef struct packed {
		logic signed [COORD_W-1:0]  d;
		logic signed [NORMAL_W-1:0] nz;
		logic signed [NORMAL_W-1:0] ny;
		logic signed [NORMAL_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [RADIUS_W-1:0]       r;
	} sphere_t;

	// Word handed from cell to cell
	typedef struct packed {
		logic    valid;
		sphere_t sphere;
		logic    outside;
		logic    straddle;
	} wave_t;

endpackage

FILE: design/sfc_cell.sv
module sfc_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [sfc_pkg::PLANE_W-1:0]         wr_data,
	input  sfc_pkg::wave_t                      wave_in,
	output sfc_pkg::wave_t                      wave_out
);

	sfc_pkg::plane_t plane_q;

	logic                                  valid_s1;
	sfc_pkg::sphere_t                      sphere_s1;
	logic                                  outside_s1;
	logic                                  straddle_s1;
	logic signed [sfc_pkg::PROD_W-1:0]     px_s1;
	logic signed [sfc_pkg::PROD_W-1:0]     py_s1;
	logic signed [sfc_pkg::PROD_W-1:0]     pz_s1;
	logic signed [sfc_pkg::COORD_W-1:0]    d_s1;

	logic                                  valid_s2;
	sfc_pkg::sphere_t                      sphere_s2;
	logic                                  outside_s2;
	logic                                  straddle_s2;
	logic signed [sfc_pkg::DIST_W-1:0]     dist_s2;

	logic                                  valid_s3;
	sfc_pkg::sphere_t                      sphere_s3;
	logic                                  outside_s3;
	logic                                  straddle_s3;

	logic signed [sfc_pkg::DIST_W-1:0]     dist_sum;
	logic signed [sfc_pkg::DIST_W-1:0]     d_ext;
	logic signed [sfc_pkg::DIST_W-1:0]     r_ext;
	logic signed [sfc_pkg::DIST_W-1:0]     r_neg;
	logic                                  is_out;
	logic                                  is_straddle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (wr_en) begin
			plane_q <= sfc_pkg::plane_t'(wr_data);
		end
	end

	// Stage 1: three products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= wave_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		sphere_s1   <= wave_in.sphere;
		outside_s1  <= wave_in.outside;
		straddle_s1 <= wave_in.straddle;
		px_s1       <= plane_q.nx * wave_in.sphere.cx;
		py_s1       <= plane_q.ny * wave_in.sphere.cy;
		pz_s1       <= plane_q.nz * wave_in.sphere.cz;
		d_s1        <= plane_q.d;
	end

	// Stage 2: signed distance, exact
	always_comb begin
		d_ext    = {{(sfc_pkg::DIST_W - sfc_pkg::COORD_W - sfc_pkg::NORM_FRAC)
			{d_s1[sfc_pkg::COORD_W-1]}}, d_s1, {sfc_pkg::NORM_FRAC{1'b0}}};
		dist_sum = sfc_pkg::DIST_W'(px_s1) + sfc_pkg::DIST_W'(py_s1)
			+ sfc_pkg::DIST_W'(pz_s1) + d_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sphere_s2   <= sphere_s1;
		outside_s2  <= outside_s1;
		straddle_s2 <= straddle_s1;
		dist_s2     <= dist_sum;
	end

	// Stage 3: compare against the radius, merge flags
	always_comb begin
		r_ext = {{(sfc_pkg::DIST_W - sfc_pkg::RADIUS_W - sfc_pkg::NORM_FRAC){1'b0}},
			sphere_s2.r, {sfc_pkg::NORM_FRAC{1'b0}}};
		r_neg       = -r_ext;
		is_out      = dist_s2 < r_neg;
		is_straddle = (dist_s2 > r_neg) && (dist_s2 < r_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sphere_s3   <= sphere_s2;
		outside_s3  <= outside_s2 | is_out;
		straddle_s3 <= straddle_s2 | is_straddle;
	end

	assign wave_out = '{valid: valid_s3, sphere: sphere_s3, outside: outside_s3,
		straddle: straddle_s3};

endmodule

FILE: design/sphere_frustum_cull_test_core.sv
// Sphere versus frustum classifier.
//
// Command channel: present center_x/y/z and radius with start high; the word
// is taken at any rising edge where start is high and busy is low. busy stays
// low, so a new sphere can be issued on every clock.
// Result channel: done pulses for one cycle with verdict (0 inside,
// 1 intersecting, 2 outside). The receiver cannot stall; it must take the
// word in that cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 near, 1 far, 2 left,
// 3 right, 4 top, 5 bottom) and cfg_data. cfg_ready is always high; indexes
// six and seven are dropped. Write planes only while no sphere is in flight.
// Each sphere passes through the registered steps of every cell and then the
// output register before its verdict; PLANE_COUNT is capped at six planes.
// Throughput is one sphere per cycle, set by the chain of plane cells: each
// cell multiplies, sums and compares in three registered steps, then hands
// the word on.
// Reset: arst_n clears all planes to zero and flushes the chain; no done
// pulses until a sphere is issued after reset.
module sphere_frustum_cull_test_core #(
	parameter int unsigned PLANE_COUNT = 6
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [sfc_pkg::COORD_W-1:0]      center_x,
	input  logic signed [sfc_pkg::COORD_W-1:0]      center_y,
	input  logic signed [sfc_pkg::COORD_W-1:0]      center_z,
	input  logic [sfc_pkg::RADIUS_W-1:0]            radius,
	output logic                                    done,
	output logic [1:0]                              verdict,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [sfc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [sfc_pkg::PLANE_W-1:0]             cfg_data
);

	// Only the six plane registers exist; cap the chain there.
	localparam int unsigned CELL_COUNT = (PLANE_COUNT > sfc_pkg::NUM_PLANE_REGS) ?
		sfc_pkg::NUM_PLANE_REGS : PLANE_COUNT;

	sfc_pkg::wave_t chain [CELL_COUNT+1];

	logic       done_q;
	logic [1:0] verdict_q;

	// The chain never blocks; config is always taken.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Launch the word into the first cell with clear flags.
	always_comb begin
		chain[0].valid     = start;
		chain[0].sphere.cx = center_x;
		chain[0].sphere.cy = center_y;
		chain[0].sphere.cz = center_z;
		chain[0].sphere.r  = radius;
		chain[0].outside   = 1'b0;
		chain[0].straddle  = 1'b0;
	end

	// One cell per plane; each owns its plane register.
	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		sfc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (cfg_valid && (cfg_index == sfc_pkg::CFG_IDX_W'(i))),
			.wr_data  (cfg_data),
			.wave_in  (chain[i]),
			.wave_out (chain[i+1])
		);
	end

	// Resolve the verdict: outside wins over intersecting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[CELL_COUNT].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chain[CELL_COUNT].outside) begin
			verdict_q <= sfc_pkg::VERDICT_OUTSIDE;
		end else if (chain[CELL_COUNT].straddle) begin
			verdict_q <= sfc_pkg::VERDICT_INTERSECTING;
		end else begin
			verdict_q <= sfc_pkg::VERDICT_INSIDE;
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

endmodule

FILE: design/sfc_checker.sv
module sfc_checker #(
	parameter int unsigned PLANE_COUNT = 6
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] verdict,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	localparam int unsigned CELL_COUNT = (PLANE_COUNT > sfc_pkg::NUM_PLANE_REGS) ?
		sfc_pkg::NUM_PLANE_REGS : PLANE_COUNT;
	localparam int unsigned LATENCY = 3 * CELL_COUNT + 1;

	// Every accepted sphere yields a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted sphere produced no result");

	// No result without a sphere accepted one latency earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching sphere");

	// Verdict code is one of the three defined results.
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (verdict == sfc_pkg::VERDICT_INSIDE
			|| verdict == sfc_pkg::VERDICT_INTERSECTING
			|| verdict == sfc_pkg::VERDICT_OUTSIDE))
		else $error("undefined verdict code");

	// Config writes are never held off.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind sphere_frustum_cull_test_core sfc_checker #(
	.PLANE_COUNT (PLANE_COUNT)
) u_sfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.verdict   (verdict),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Checked plane count, and the depth of the plane chain: three registered
	// steps per plane plus the output register.
	localparam int unsigned PLANE_COUNT = 6;
	localparam int unsigned LATENCY     = 3 * PLANE_COUNT + 1;
	localparam int unsigned CYCLE_LIMIT = 100000;

	// Register indexes of the config channel; the two spares are dropped.
	typedef enum logic [sfc_pkg::CFG_IDX_W-1:0] {
		PLANE_NEAR,
		PLANE_FAR,
		PLANE_LEFT,
		PLANE_RIGHT,
		PLANE_TOP,
		PLANE_BOTTOM,
		PLANE_SPARE6,
		PLANE_SPARE7
	} plane_idx_t;

	// Own copy of the planes and the queue of verdicts still to come out.
	class cull_scoreboard;
		sfc_pkg::plane_t planes [sfc_pkg::NUM_PLANE_REGS];
		logic [1:0]      verdicts_due [$];
		int unsigned     errors;

		function new();
			foreach (planes[i]) planes[i] = '0;
			errors = 0;
		endfunction

		function void set_plane(logic [sfc_pkg::CFG_IDX_W-1:0] idx,
				logic [sfc_pkg::PLANE_W-1:0] data);
			if (idx < sfc_pkg::NUM_PLANE_REGS)
				planes[idx] = data;
		endfunction

		// Signed distance per plane in Q.18, exact in 64 bits.
		function logic [1:0] classify(logic signed [sfc_pkg::COORD_W-1:0] cx,
				logic signed [sfc_pkg::COORD_W-1:0] cy,
				logic signed [sfc_pkg::COORD_W-1:0] cz,
				logic [sfc_pkg::RADIUS_W-1:0] r);
			int unsigned n_checked;
			logic signed [sfc_pkg::NORMAL_W-1:0] nx, ny, nz;
			logic signed [sfc_pkg::COORD_W-1:0]  d;
			longint rad, dist_v, mag;
			bit outside, straddle;
			n_checked = (PLANE_COUNT > sfc_pkg::NUM_PLANE_REGS) ?
				sfc_pkg::NUM_PLANE_REGS : PLANE_COUNT;
			rad = longint'(r) * (longint'(1) << sfc_pkg::NORM_FRAC);
			outside = 0;
			straddle = 0;
			for (int unsigned i = 0; i < n_checked; i++) begin
				nx = planes[i].nx;
				ny = planes[i].ny;
				nz = planes[i].nz;
				d  = planes[i].d;
				dist_v = longint'(nx) * longint'(cx) + longint'(ny) * longint'(cy)
					+ longint'(nz) * longint'(cz)
					+ longint'(d) * (longint'(1) << sfc_pkg::NORM_FRAC);
				mag = (dist_v < 0) ? -dist_v : dist_v;
				if (dist_v < -rad)
					outside = 1;
				else if (mag < rad)
					straddle = 1;
			end
			if (outside)
				return sfc_pkg::VERDICT_OUTSIDE;
			if (straddle)
				return sfc_pkg::VERDICT_INTERSECTING;
			return sfc_pkg::VERDICT_INSIDE;
		endfunction

		function void note_sphere(logic signed [sfc_pkg::COORD_W-1:0] cx,
				logic signed [sfc_pkg::COORD_W-1:0] cy,
				logic signed [sfc_pkg::COORD_W-1:0] cz,
				logic [sfc_pkg::RADIUS_W-1:0] r);
			verdicts_due.push_back(classify(cx, cy, cz, r));
		endfunction

		function void check_verdict(logic [1:0] got);
			logic [1:0] want;
			if (verdicts_due.size() == 0) begin
				$error("verdict: no sphere pending, expected none, actual %0d", got);
				errors++;
				return;
			end
			want = verdicts_due.pop_front();
			if (got !== want) begin
				$error("verdict mismatch: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction
	endclass

	// Every input is known from time zero; reset is held low from the start.
	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                start     = 1'b0;
	logic signed [sfc_pkg::COORD_W-1:0]  center_x  = '0;
	logic signed [sfc_pkg::COORD_W-1:0]  center_y  = '0;
	logic signed [sfc_pkg::COORD_W-1:0]  center_z  = '0;
	logic [sfc_pkg::RADIUS_W-1:0]        radius    = '0;
	logic                                cfg_valid = 1'b0;
	logic [sfc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [sfc_pkg::PLANE_W-1:0]         cfg_data  = '0;
	logic                                busy;
	logic                                done;
	logic [1:0]                          verdict;
	logic                                cfg_ready;

	cull_scoreboard  sb;
	sfc_pkg::plane_t plane_set [sfc_pkg::NUM_PLANE_REGS];
	int unsigned     cycle_count = 0;

	sphere_frustum_cull_test_core #(
		.PLANE_COUNT(PLANE_COUNT)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.radius    (radius),
		.done      (done),
		.verdict   (verdict),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Sample the result word at the edge that closes its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_verdict(verdict);
	end

	// Hard stop in case a result never shows up.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Pick a coordinate in [-span, span]; a span of 32768 covers the full field.
	function automatic logic signed [sfc_pkg::COORD_W-1:0] pick_coord(int span);
		if (span >= 32768)
			return sfc_pkg::COORD_W'($urandom);
		return sfc_pkg::COORD_W'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Axis-aligned face of a box around the origin, tilted by up to tilt on the
	// two other normal components: near/far face z, left/right x, top/bottom y.
	function automatic sfc_pkg::plane_t box_plane(int unsigned i, int tilt, int offset);
		sfc_pkg::plane_t p;
		logic signed [sfc_pkg::NORMAL_W-1:0] main_n;
		main_n = (i % 2 == 0) ? 16'sd16384 : -16'sd16384;
		p.nx = pick_coord(tilt);
		p.ny = pick_coord(tilt);
		p.nz = pick_coord(tilt);
		case (i / 2)
			0: p.nz = main_n;
			1: p.nx = main_n;
			default: p.ny = main_n;
		endcase
		p.d = sfc_pkg::COORD_W'(offset);
		return p;
	endfunction

	// Issue one sphere word and hold it until the core takes it. Keep start
	// high into the next word unless an idle burst is drawn.
	task automatic send_sphere(input int cx, input int cy, input int cz,
			input int r, input int gaps);
		start    <= 1'b1;
		center_x <= sfc_pkg::COORD_W'(cx);
		center_y <= sfc_pkg::COORD_W'(cy);
		center_z <= sfc_pkg::COORD_W'(cz);
		radius   <= sfc_pkg::RADIUS_W'(r);
		do @(posedge clk); while (busy);
		sb.note_sphere(sfc_pkg::COORD_W'(cx), sfc_pkg::COORD_W'(cy),
			sfc_pkg::COORD_W'(cz), sfc_pkg::RADIUS_W'(r));
		if (gaps != 0 && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic run_random(input int unsigned count, input int span,
			input int rmax, input int gaps);
		repeat (count)
			send_sphere(pick_coord(span), pick_coord(span), pick_coord(span),
				int'($urandom_range(0, rmax)), gaps);
	endtask

	// Write one plane register; drop valid after each word.
	task automatic write_reg(input plane_idx_t idx,
			input logic [sfc_pkg::PLANE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_plane(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_frustum();
		for (int unsigned i = 0; i < sfc_pkg::NUM_PLANE_REGS; i++)
			write_reg(plane_idx_t'(i), plane_set[i]);
	endtask

	// Stop issuing, wait for every verdict, then let the chain run empty.
	task automatic settle_block();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset planes are all zero: every sphere with a radius straddles,
		// a point sphere is inside, and nothing is ever outside.
		send_sphere(0, 0, 0, 0, 0);
		send_sphere(16'sh8000, 16'sh8000, 16'sh8000, 15'h7FFF, 0);
		send_sphere(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, 0);
		settle_block();

		// One live plane x >= 0, the rest pushed far away so they never
		// straddle. Hit the exact edge cases on the live plane.
		plane_set[PLANE_NEAR] = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
		for (int unsigned i = 1; i < sfc_pkg::NUM_PLANE_REGS; i++)
			plane_set[i] = {16'sh7FFF, 48'd0};
		load_frustum();
		// Spare indexes must not land anywhere.
		write_reg(PLANE_SPARE6, '0);
		write_reg(PLANE_SPARE7, {$urandom, $urandom});
		send_sphere(-5, 0, 0, 5, 0);   // distance equals minus radius
		send_sphere(5, 0, 0, 5, 0);    // distance equals radius
		send_sphere(-6, 0, 0, 5, 0);
		send_sphere(-4, 0, 0, 5, 0);
		send_sphere(-1, 0, 0, 0, 0);   // point sphere just behind the plane
		send_sphere(0, 0, 0, 0, 0);    // point sphere on the plane
		send_sphere(1, 0, 0, 0, 0);
		send_sphere(16'sh8000, 0, 0, 15'h7FFF, 0);
		send_sphere(16'sh7FFF, 0, 0, 15'h7FFF, 0);
		settle_block();

		// Axis-aligned box of half-size 1000, then random spheres around it.
		foreach (plane_set[i])
			plane_set[i] = box_plane(i, 0, 1000);
		load_frustum();
		send_sphere(0, 0, 0, 0, 0);
		send_sphere(0, 0, 0, 1500, 0);
		send_sphere(3000, 0, 0, 10, 0);
		send_sphere(0, -999, 0, 1, 0);
		run_random(180, 1500, 600, 1);
		settle_block();

		// Most negative and most positive values in every plane field.
		foreach (plane_set[i])
			plane_set[i] = {4{16'sh8000}};
		load_frustum();
		send_sphere(16'sh8000, 16'sh8000, 16'sh8000, 15'h7FFF, 0);
		send_sphere(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 0);
		send_sphere(0, 0, 0, 15'h7FFF, 0);
		settle_block();
		foreach (plane_set[i])
			plane_set[i] = {4{16'sh7FFF}};
		load_frustum();
		send_sphere(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0);
		send_sphere(16'sh8000, 16'sh8000, 16'sh8000, 0, 0);
		settle_block();

		// Unnormalized random planes against full-range spheres.
		foreach (plane_set[i])
			plane_set[i] = {$urandom, $urandom};
		load_frustum();
		run_random(100, 32768, 32767, 1);
		settle_block();

		// Tilted box with random offsets; finish without idle bursts.
		foreach (plane_set[i])
			plane_set[i] = box_plane(i, 2000, 300 + $urandom_range(0, 1700));
		load_frustum();
		run_random(150, 2048, 1024, 1);
		run_random(100, 2048, 1024, 0);
		settle_block();

		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
design/sfc_pkg.sv
design/sfc_cell.sv
design/sphere_frustum_cull_test_core.sv
design/sfc_checker.sv
sim/testbench.sv
